// ===== hdl/tvdr_pkg.sv =====
// shared types, codes and helper functions for the vertical drag recognizer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tvdr_pkg;

    // decoupling queue between the front stage and the gesture engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // configuration reset values
    localparam logic [7:0] START_THRESHOLD_RST  = 8'd8;
    localparam logic [7:0] MIN_UPDATE_COUNT_RST = 8'd2;
    localparam logic [3:0] FAIL_RATIO_RST       = 4'd3;

    typedef enum logic [1:0] {
        CFG_START_THRESHOLD  = 2'd0,
        CFG_MIN_UPDATE_COUNT = 2'd1,
        CFG_FAIL_RATIO       = 2'd2
    } t_cfg_reg;

    // raw touch event codes on the input stream
    typedef enum logic [1:0] {
        CMD_TOUCHDOWN = 2'd0,
        CMD_UPDATE    = 2'd1,
        CMD_LIFTOFF   = 2'd2,
        CMD_CANCEL    = 2'd3
    } t_cmd;

    // decoded operation, one-hot so the engine selects without a decode
    typedef enum logic [3:0] {
        OP_TOUCHDOWN = 4'b0001,
        OP_UPDATE    = 4'b0010,
        OP_LIFTOFF   = 4'b0100,
        OP_CANCEL    = 4'b1000
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_POSSIBLE = 4'b0010,
        PH_ACTIVE   = 4'b0100,
        PH_FAILED   = 4'b1000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_STARTED   = 3'd1,
        EV_UPDATED   = 3'd2,
        EV_COMPLETED = 3'd3,
        EV_FAILED    = 3'd4,
        EV_CANCELLED = 3'd5
    } t_event;

    typedef struct packed {
        t_op                op;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
    } t_item;

    // 32-bit signed add of a 17-bit difference, clamped at the 32-bit bounds
    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [16:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {{16{b[16]}}, b};
        if (s[32] != s[31]) begin
            sat_add32 = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add32 = s[31:0];
        end
    endfunction

    // magnitude; the most negative value maps to 2^31 unsigned
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // clamp to the signed 16-bit range
    function automatic logic signed [15:0] sat16(input logic signed [33:0] d);
        if (d > 34'sd32767) begin
            sat16 = 16'sh7fff;
        end else if (d < -34'sd32768) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = d[15:0];
        end
    endfunction

endpackage

// ===== hdl/tvdr_front.sv =====
// front stage: accepts touch events and decodes the command into an operation
// depends on tvdr_pkg
`timescale 1ns / 1ps

module tvdr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic [15:0]        i_pos_x,
    input  logic [15:0]        i_pos_y,
    output logic               o_valid,
    input  logic               i_ready,
    output tvdr_pkg::t_item    o_item
);
    import tvdr_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_op   w_op;

    always_comb begin
        unique case (t_cmd'(i_cmd))
            CMD_TOUCHDOWN: w_op = OP_TOUCHDOWN;
            CMD_UPDATE:    w_op = OP_UPDATE;
            CMD_LIFTOFF:   w_op = OP_LIFTOFF;
            default:       w_op = OP_CANCEL;
        endcase
    end

    // holding register is free when empty or draining this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.op    <= w_op;
            r_item.pos_x <= i_pos_x;
            r_item.pos_y <= i_pos_y;
        end
    end

endmodule

// ===== hdl/tvdr_queue.sv =====
// small fifo of decoded events between the front stage and the gesture engine
// depends on tvdr_pkg
`timescale 1ns / 1ps

module tvdr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  tvdr_pkg::t_item    i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output tvdr_pkg::t_item    o_item
);
    import tvdr_pkg::*;

    t_item                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== hdl/tvdr_engine.sv =====
// gesture engine: phase tracking, running sums, start test and result register
// depends on tvdr_pkg
`timescale 1ns / 1ps

module tvdr_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  tvdr_pkg::t_item    i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_event_kind,
    output logic [15:0]        o_delta_y
);
    import tvdr_pkg::*;

    logic [7:0]          r_start_threshold;
    logic [7:0]          r_min_update_count;
    logic [3:0]          r_fail_ratio;

    t_phase              r_phase,  n_phase;
    logic signed [15:0]  r_last_x, n_last_x;
    logic signed [15:0]  r_last_y, n_last_y;
    logic signed [31:0]  r_sum_dx, n_sum_dx;
    logic signed [31:0]  r_sum_dy, n_sum_dy;
    logic [7:0]          r_count,  n_count;

    logic                r_out_valid;
    t_event              r_out_kind,  n_out_kind;
    logic signed [15:0]  r_out_delta, n_out_delta;

    logic                w_take;
    logic signed [16:0]  w_dx;
    logic signed [16:0]  w_dy;
    logic signed [31:0]  w_sum_dx;
    logic signed [31:0]  w_sum_dy;
    logic [7:0]          w_count;
    logic [31:0]         w_mag_dx;
    logic [31:0]         w_mag_dy;
    logic [35:0]         w_limit;
    logic signed [33:0]  w_sum_dy_ext;
    logic signed [33:0]  w_thr_ext;
    logic signed [33:0]  w_start_delta;

    // result register drains or is empty: take the next event
    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_threshold  <= START_THRESHOLD_RST;
            r_min_update_count <= MIN_UPDATE_COUNT_RST;
            r_fail_ratio       <= FAIL_RATIO_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_START_THRESHOLD:  r_start_threshold  <= i_cfg_data;
                CFG_MIN_UPDATE_COUNT: r_min_update_count <= i_cfg_data;
                CFG_FAIL_RATIO:       r_fail_ratio       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // motion arithmetic for a position update
    always_comb begin
        w_dx     = {i_item.pos_x[15], i_item.pos_x} - {r_last_x[15], r_last_x};
        w_dy     = {i_item.pos_y[15], i_item.pos_y} - {r_last_y[15], r_last_y};
        w_sum_dx = sat_add32(r_sum_dx, w_dx);
        w_sum_dy = sat_add32(r_sum_dy, w_dy);
        w_count  = (r_count < r_min_update_count) ? r_count + 8'd1 : r_count;
        w_mag_dx = mag32(w_sum_dx);
        w_mag_dy = mag32(w_sum_dy);
        w_limit  = 36'(r_fail_ratio) * 36'(w_mag_dy);
        // signed threshold is negative unless the travel is downward
        w_sum_dy_ext  = {{2{w_sum_dy[31]}}, w_sum_dy};
        w_thr_ext     = {26'd0, r_start_threshold};
        w_start_delta = (w_sum_dy > 32'sd0) ? w_sum_dy_ext - w_thr_ext
                                            : w_sum_dy_ext + w_thr_ext;
    end

    always_comb begin
        n_phase     = r_phase;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_sum_dx    = r_sum_dx;
        n_sum_dy    = r_sum_dy;
        n_count     = r_count;
        n_out_kind  = EV_NONE;
        n_out_delta = '0;
        unique case (i_item.op)
            OP_TOUCHDOWN: begin
                n_phase  = PH_POSSIBLE;
                n_last_x = i_item.pos_x;
                n_last_y = i_item.pos_y;
                n_sum_dx = '0;
                n_sum_dy = '0;
                n_count  = '0;
            end
            OP_UPDATE: begin
                if (r_phase == PH_POSSIBLE || r_phase == PH_ACTIVE) begin
                    n_last_x = i_item.pos_x;
                    n_last_y = i_item.pos_y;
                    n_sum_dx = w_sum_dx;
                    n_sum_dy = w_sum_dy;
                    n_count  = w_count;
                    if (r_phase == PH_ACTIVE) begin
                        n_out_kind  = EV_UPDATED;
                        n_out_delta = sat16({{17{w_dy[16]}}, w_dy});
                    end else if (w_count >= r_min_update_count &&
                                 w_mag_dy >= {24'd0, r_start_threshold}) begin
                        if ({4'd0, w_mag_dx} >= w_limit) begin
                            n_phase    = PH_FAILED;
                            n_out_kind = EV_FAILED;
                        end else begin
                            n_phase     = PH_ACTIVE;
                            n_out_kind  = EV_STARTED;
                            n_out_delta = sat16(w_start_delta);
                        end
                    end
                end
            end
            OP_LIFTOFF: begin
                if (r_phase == PH_POSSIBLE) begin
                    n_out_kind = EV_FAILED;
                end else if (r_phase == PH_ACTIVE) begin
                    n_out_kind = EV_COMPLETED;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                if (r_phase == PH_ACTIVE) begin
                    n_out_kind = EV_CANCELLED;
                end
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_sum_dx    <= '0;
            r_sum_dy    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_phase  <= n_phase;
                r_last_x <= n_last_x;
                r_last_y <= n_last_y;
                r_sum_dx <= n_sum_dx;
                r_sum_dy <= n_sum_dy;
                r_count  <= n_count;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_kind  <= n_out_kind;
            r_out_delta <= n_out_delta;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_event_kind = r_out_kind;
    assign o_delta_y    = r_out_delta;

    // an event is only consumed when the result register can hold its word
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!r_out_valid || i_ready))
        else $error("engine consumed an event while the result was stalled");

    // a start always leaves the gesture active
    a_start_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && n_out_kind == EV_STARTED) |=> (r_phase == PH_ACTIVE))
        else $error("start event without entering the active phase");

    // only started and updated words carry a delta
    a_zero_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != EV_STARTED && r_out_kind != EV_UPDATED)
            |-> (r_out_delta == 16'sd0))
        else $error("non-motion event with a nonzero delta");

    // every liftoff or cancel returns to idle
    a_end_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_item.op == OP_LIFTOFF || i_item.op == OP_CANCEL))
            |=> (r_phase == PH_IDLE))
        else $error("gesture did not return to idle");

endmodule

// ===== hdl/touch_vertical_drag_recognizer.sv =====
// top level of the vertical drag recognizer: front stage, queue, gesture engine
// depends on tvdr_pkg, tvdr_front, tvdr_queue, tvdr_engine
`timescale 1ns / 1ps

// Vertical drag recognizer. Each touch word on the input stream (touchdown,
// position update, liftoff, cancel with a signed x/y point) produces exactly
// one result word: an event kind (none, started, updated, completed, failed,
// cancelled) and a saturated 16-bit vertical delta. Throughput is one word per
// clock while the result stream does not stall: the gesture engine computes
// the state update for a word combinationally (two 17-bit differences, two
// saturating 32-bit sums, one 4x32 multiply and compares), so it takes a new
// word whenever its result register is empty or draining. A word is registered
// in turn in the front holding register, the decoupling queue and the result
// register. The four-entry queue lets the input side keep flowing for a few
// words while the output side is stalled. Configuration registers are written
// through the cfg port only while the block is idle: this binds the user, as
// the block has no check for it. The port is always ready. Writes to an index
// beyond the register list are accepted and ignored.

module touch_vertical_drag_recognizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,   // 0 start_threshold, 1 min_update_count, 2 fail ratio
    input  logic [7:0]  i_cfg_data,
    // touch event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] pos_x, [31:16] pos_y
    input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
    // gesture result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [15:0] delta_y
    output logic [2:0]  m_axis_tuser   // [2:0] event_kind
);
    import tvdr_pkg::*;

    // front stage to queue
    logic  w_fq_valid;
    logic  w_fq_ready;
    t_item w_fq_item;

    // queue to engine
    logic  w_qe_valid;
    logic  w_qe_ready;
    t_item w_qe_item;

    // registers sit in the engine and take a write every cycle
    assign o_cfg_ready = 1'b1;

    // decode the command and hold the word in a register
    tvdr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_pos_x (s_axis_tdata[15:0]),
        .i_pos_y (s_axis_tdata[31:16]),
        .o_valid (w_fq_valid),
        .i_ready (w_fq_ready),
        .o_item  (w_fq_item)
    );

    // decoupling queue so each side stalls on its own
    tvdr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .o_ready (w_fq_ready),
        .i_item  (w_fq_item),
        .o_valid (w_qe_valid),
        .i_ready (w_qe_ready),
        .o_item  (w_qe_item)
    );

    // gesture state and result register
    tvdr_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (w_qe_valid),
        .o_ready      (w_qe_ready),
        .i_item       (w_qe_item),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_event_kind (m_axis_tuser),
        .o_delta_y    (m_axis_tdata)
    );

endmodule
